// File: rtl/tkes_pkg.sv
// shared types, constants and helpers of the top-k edge keep selector
package tkes_pkg;

    localparam int MAX_KEEP = 1024;
    localparam int DEPTH    = MAX_KEEP + 1;
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int PRI_W    = 26;
    localparam int ID_W     = 20;
    localparam int ARR_W    = 20;
    localparam int PROB_W   = 17;
    localparam int PEN_W    = 16;
    localparam int WGT_W    = 16;
    localparam int KEEP_W   = 11;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W    = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_KEEP_COUNT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PENALTY_ENABLE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PENALTY_WEIGHT = 2'd2;

    typedef struct packed {
        logic signed [PRI_W-1:0] pri;
        logic [ID_W-1:0]         id;
        logic [ARR_W-1:0]        arr;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_PRI, S_UPC, S_UPW, S_CHK,
        S_ROOT, S_LAST, S_DNL, S_DNR, S_DNW
    } t_state;

    // lower priority, earlier arrival breaks a tie
    function automatic logic lower(input t_entry a, input t_entry b);
        if (a.pri != b.pri) begin
            return a.pri < b.pri;
        end
        return a.arr < b.arr;
    endfunction

endpackage

// File: rtl/tkes_ram.sv
// simple dual-port ram, one write port, one registered read port
module tkes_ram #(
    parameter int DEPTH = 1025,
    parameter int WIDTH = 66
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/tkes_pri.sv
// priority unit: registered penalty product, then subtract and saturate
module tkes_pri (
    input  logic                                i_clk,
    input  logic                                i_pen_en,
    input  logic [tkes_pkg::WGT_W-1:0]          i_weight,
    input  logic [tkes_pkg::PEN_W-1:0]          i_pen,
    input  logic [tkes_pkg::PROB_W-1:0]         i_prob,
    output logic signed [tkes_pkg::PRI_W-1:0]   o_pri
);
    import tkes_pkg::*;

    localparam int PROD_W = WGT_W + PEN_W;
    localparam int DIFF_W = PRI_W + 1;

    logic [PROD_W-1:0]        r_prod;
    logic signed [DIFF_W-1:0] diff;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_weight) * PROD_W'(i_pen);
    end

    always_comb begin
        diff = signed'(DIFF_W'(i_prob));
        if (i_pen_en) begin
            diff = diff - signed'(DIFF_W'(r_prod[PROD_W-1:8]));
        end
        if (diff[DIFF_W-1] != diff[DIFF_W-2]) begin
            o_pri = diff[DIFF_W-1] ? {1'b1, {(PRI_W-1){1'b0}}} : {1'b0, {(PRI_W-1){1'b1}}};
        end else begin
            o_pri = diff[PRI_W-1:0];
        end
    end
endmodule

// File: rtl/top_k_edge_keep_selector.sv
// top level: heap sequencer around the entry memory
// steps: MUL, PRI, then UPC per level climbed or UPW at the root, then CHK; an eviction adds
//   ROOT (held while the eviction output is full), LAST, DNL and DNR per level descended, DNW at a leaf
// flow: one item at a time, o_ready is low until the sequencer is back in S_IDLE
// reset: heap empty, arrival count zero, keep_count 1024, penalty off, weight zero
// heap memory contents are not cleared; only entries below the heap size are read
module top_k_edge_keep_selector (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // item input
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [tkes_pkg::ID_W-1:0]           i_edge_id,
    input  logic [tkes_pkg::PROB_W-1:0]         i_keep_prob,
    input  logic [tkes_pkg::PEN_W-1:0]          i_penalty_points,
    input  logic                                i_first,
    // eviction output
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [tkes_pkg::ID_W-1:0]           o_evicted_id,
    output logic signed [tkes_pkg::PRI_W-1:0]   o_evicted_priority,
    // configuration writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [tkes_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tkes_pkg::CFG_W-1:0]          i_cfg_data
);
    import tkes_pkg::*;

    localparam int CIDX_W = IDX_W + 1;

    t_state r_state, n_state;

    logic [KEEP_W-1:0]  r_keep;
    logic               r_pen_en;
    logic [WGT_W-1:0]   r_weight;

    logic [IDX_W-1:0]   r_size, n_size;
    logic [ARR_W-1:0]   r_arrival, n_arrival;
    logic [ID_W-1:0]    r_id;
    logic [PROB_W-1:0]  r_prob;
    logic [PEN_W-1:0]   r_pen;
    t_entry             r_cur, n_cur;
    t_entry             r_best, n_best;
    logic               r_best_ch, n_best_ch;
    logic [IDX_W-1:0]   r_best_idx, n_best_idx;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic               r_out_valid, n_out_valid;
    logic [ID_W-1:0]    r_out_id, n_out_id;
    logic signed [PRI_W-1:0] r_out_pri, n_out_pri;

    // memory port
    logic               mem_we, mem_re;
    logic [IDX_W-1:0]   mem_waddr, mem_raddr;
    t_entry             mem_wdata, mem_rdata;
    logic [ENTRY_W-1:0] mem_rbits;

    logic signed [PRI_W-1:0] pri;
    logic               accept;
    logic [IDX_W-1:0]   limit;
    logic               out_free;

    // sift-down decision
    logic [CIDX_W-1:0]  left_idx, right_idx, next_left;
    logic               right_ok;
    t_entry             base;
    logic               go_child;
    t_entry             child_val;
    logic [IDX_W-1:0]   child_idx;
    logic [IDX_W-1:0]   parent_idx;

    assign accept      = i_valid && o_ready;
    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_out_valid;
    assign o_evicted_id       = r_out_id;
    assign o_evicted_priority = r_out_pri;
    assign out_free    = !r_out_valid || i_ready;
    assign limit       = (r_keep > KEEP_W'(MAX_KEEP)) ? IDX_W'(MAX_KEEP) : IDX_W'(r_keep);
    assign mem_rdata   = t_entry'(mem_rbits);
    assign parent_idx  = (r_idx - IDX_W'(1)) >> 1;

    tkes_ram #(.DEPTH(DEPTH), .WIDTH(ENTRY_W)) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rbits)
    );

    tkes_pri u_pri (
        .i_clk    (i_clk),
        .i_pen_en (r_pen_en),
        .i_weight (r_weight),
        .i_pen    (r_pen),
        .i_prob   (r_prob),
        .o_pri    (pri)
    );

    // pick the child to move up while descending
    always_comb begin
        left_idx  = {r_idx, 1'b1};
        right_idx = {r_idx, 1'b0} + CIDX_W'(2);
        right_ok  = right_idx < CIDX_W'(r_size);
        base      = r_best_ch ? r_best : r_cur;
        go_child  = 1'b0;
        child_val = mem_rdata;
        child_idx = left_idx[IDX_W-1:0];
        if (r_state == S_DNR) begin
            if (lower(mem_rdata, base)) begin
                go_child  = 1'b1;
                child_val = mem_rdata;
                child_idx = right_idx[IDX_W-1:0];
            end else begin
                go_child  = r_best_ch;
                child_val = r_best;
                child_idx = r_best_idx;
            end
        end else begin
            go_child = lower(mem_rdata, r_cur);
        end
        next_left = {child_idx, 1'b1};
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (accept) n_state = S_MUL;
            S_MUL:  n_state = S_PRI;
            S_PRI:  n_state = (r_size == '0) ? S_UPW : S_UPC;
            S_UPC: begin
                if (lower(r_cur, mem_rdata)) begin
                    n_state = (parent_idx == '0) ? S_UPW : S_UPC;
                end else begin
                    n_state = S_CHK;
                end
            end
            S_UPW:  n_state = S_CHK;
            S_CHK:  n_state = (r_size > limit) ? S_ROOT : S_IDLE;
            S_ROOT: begin
                if (out_free) begin
                    n_state = (r_size > IDX_W'(1)) ? S_LAST : S_IDLE;
                end
            end
            S_LAST: n_state = (r_size > IDX_W'(1)) ? S_DNL : S_IDLE;
            S_DNL, S_DNR: begin
                if (r_state == S_DNL && right_ok) begin
                    n_state = S_DNR;
                end else if (go_child) begin
                    n_state = (next_left < CIDX_W'(r_size)) ? S_DNL : S_DNW;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DNW:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_size      = r_size;
        n_arrival   = r_arrival;
        n_cur       = r_cur;
        n_best      = r_best;
        n_best_ch   = r_best_ch;
        n_best_idx  = r_best_idx;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !i_ready;
        n_out_id    = r_out_id;
        n_out_pri   = r_out_pri;
        mem_we      = 1'b0;
        mem_waddr   = r_idx;
        mem_wdata   = r_cur;
        mem_re      = 1'b0;
        mem_raddr   = parent_idx;
        case (r_state)
            S_IDLE: begin
                if (accept && i_first) begin
                    n_size    = '0;
                    n_arrival = '0;
                end
            end
            S_PRI: begin
                n_cur     = '{pri: pri, id: r_id, arr: r_arrival};
                n_arrival = r_arrival + ARR_W'(1);
                n_idx     = r_size;
                n_size    = r_size + IDX_W'(1);
                mem_re    = 1'b1;
                mem_raddr = (r_size - IDX_W'(1)) >> 1;
            end
            S_UPC: begin
                if (lower(r_cur, mem_rdata)) begin
                    // parent moves down into the hole
                    mem_we    = 1'b1;
                    mem_wdata = mem_rdata;
                    n_idx     = parent_idx;
                    mem_re    = 1'b1;
                    mem_raddr = (parent_idx - IDX_W'(1)) >> 1;
                end else begin
                    mem_we = 1'b1;
                end
            end
            S_UPW, S_DNW: mem_we = 1'b1;
            S_CHK: begin
                mem_re    = 1'b1;
                mem_raddr = '0;
            end
            S_ROOT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_id    = mem_rdata.id;
                    n_out_pri   = mem_rdata.pri;
                    n_size      = r_size - IDX_W'(1);
                    mem_re      = 1'b1;
                    mem_raddr   = r_size - IDX_W'(1);
                end
            end
            S_LAST: begin
                n_cur     = mem_rdata;
                n_idx     = '0;
                mem_re    = 1'b1;
                mem_raddr = IDX_W'(1);
                if (r_size <= IDX_W'(1)) begin
                    mem_we    = 1'b1;
                    mem_waddr = '0;
                    mem_wdata = mem_rdata;
                end
            end
            S_DNL, S_DNR: begin
                if (r_state == S_DNL && right_ok) begin
                    n_best     = mem_rdata;
                    n_best_ch  = go_child;
                    n_best_idx = left_idx[IDX_W-1:0];
                    mem_re     = 1'b1;
                    mem_raddr  = right_idx[IDX_W-1:0];
                end else if (go_child) begin
                    mem_we    = 1'b1;
                    mem_wdata = child_val;
                    n_idx     = child_idx;
                    n_best_ch = 1'b0;
                    mem_re    = 1'b1;
                    mem_raddr = next_left[IDX_W-1:0];
                end else begin
                    mem_we    = 1'b1;
                    n_best_ch = 1'b0;
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_size      <= '0;
            r_arrival   <= '0;
            r_out_valid <= 1'b0;
            r_best_ch   <= 1'b0;
            r_keep      <= KEEP_W'(MAX_KEEP);
            r_pen_en    <= 1'b0;
            r_weight    <= '0;
        end else begin
            r_state     <= n_state;
            r_size      <= n_size;
            r_arrival   <= n_arrival;
            r_out_valid <= n_out_valid;
            r_best_ch   <= n_best_ch;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_KEEP_COUNT:     r_keep   <= i_cfg_data[KEEP_W-1:0];
                    CFG_PENALTY_ENABLE: r_pen_en <= i_cfg_data[0];
                    CFG_PENALTY_WEIGHT: r_weight <= i_cfg_data[WGT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_id   <= i_edge_id;
            r_prob <= i_keep_prob;
            r_pen  <= i_penalty_points;
        end
        r_cur      <= n_cur;
        r_best     <= n_best;
        r_best_idx <= n_best_idx;
        r_idx      <= n_idx;
        r_out_id   <= n_out_id;
        r_out_pri  <= n_out_pri;
    end
endmodule

// File: tb/sv/tb_top.sv
// testbench of the top-k edge keep selector: heap predictor, directed and random tests
module tb_top;
    import tkes_pkg::*;

    typedef struct {
        logic [ID_W-1:0]         id;
        logic signed [PRI_W-1:0] pri;
    } t_eviction;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    // item channel
    logic              i_valid = 1'b0;
    logic              o_ready;
    logic [ID_W-1:0]   i_edge_id = '0;
    logic [PROB_W-1:0] i_keep_prob = '0;
    logic [PEN_W-1:0]  i_penalty_points = '0;
    logic              i_first = 1'b0;

    // eviction channel
    logic                    o_valid;
    logic                    i_ready = 1'b0;
    logic [ID_W-1:0]         o_evicted_id;
    logic signed [PRI_W-1:0] o_evicted_priority;

    // register writes
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    localparam int SETTLE_CYCLES = 80;
    localparam int WATCHDOG_LIMIT = 20000;

    // predicted block state
    logic signed [PRI_W-1:0] mdl_pri [0:MAX_KEEP];
    logic [ID_W-1:0]         mdl_id  [0:MAX_KEEP];
    logic [ARR_W-1:0]        mdl_arr [0:MAX_KEEP];
    int unsigned             mdl_size;
    logic [ARR_W-1:0]        mdl_arrivals;
    logic [KEEP_W-1:0]       mdl_keep;
    logic                    mdl_pen_on;
    logic [WGT_W-1:0]        mdl_weight;

    t_eviction pending_evictions[$];
    int        errors = 0;
    int        idle_cycles = 0;
    bit        quiet = 1'b0;
    int        out_stall = 0;

    top_k_edge_keep_selector dut (.*);

    always #6 i_clk = ~i_clk;

    // lower priority ranks below, earlier arrival breaks a tie
    function automatic bit ranks_below(int unsigned a, int unsigned b);
        if (mdl_pri[a] != mdl_pri[b]) begin
            return mdl_pri[a] < mdl_pri[b];
        end
        return mdl_arr[a] < mdl_arr[b];
    endfunction

    function automatic void swap_entries(int unsigned a, int unsigned b);
        logic signed [PRI_W-1:0] p;
        logic [ID_W-1:0]         e;
        logic [ARR_W-1:0]        r;
        p = mdl_pri[a]; e = mdl_id[a]; r = mdl_arr[a];
        mdl_pri[a] = mdl_pri[b]; mdl_id[a] = mdl_id[b]; mdl_arr[a] = mdl_arr[b];
        mdl_pri[b] = p; mdl_id[b] = e; mdl_arr[b] = r;
    endfunction

    // insert one edge into the predicted heap, queue the eviction it causes
    function automatic void rank_insert(logic [ID_W-1:0] id, logic [PROB_W-1:0] prob,
                                        logic [PEN_W-1:0] pen, logic first);
        longint      pri;
        int unsigned limit;
        int unsigned i;
        int unsigned parent;
        int unsigned l;
        int unsigned r;
        int unsigned m;
        t_eviction   ev;
        limit = (mdl_keep > MAX_KEEP) ? MAX_KEEP : mdl_keep;
        if (first) begin
            mdl_size = 0;
            mdl_arrivals = '0;
        end
        pri = longint'(prob);
        if (mdl_pen_on) begin
            pri = pri - longint'((64'(mdl_weight) * 64'(pen)) >> 8);
        end
        if (pri > 33554431) pri = 33554431;
        if (pri < -33554432) pri = -33554432;
        if (mdl_size > MAX_KEEP) mdl_size = MAX_KEEP;
        i = mdl_size;
        mdl_pri[i] = pri[PRI_W-1:0];
        mdl_id[i] = id;
        mdl_arr[i] = mdl_arrivals;
        mdl_size++;
        mdl_arrivals = mdl_arrivals + 1'b1;
        while (i > 0) begin
            parent = (i - 1) / 2;
            if (!ranks_below(i, parent)) break;
            swap_entries(i, parent);
            i = parent;
        end
        if (mdl_size > limit) begin
            ev.id = mdl_id[0];
            ev.pri = mdl_pri[0];
            pending_evictions = {pending_evictions, ev};
            mdl_size--;
            if (mdl_size > 0) begin
                mdl_pri[0] = mdl_pri[mdl_size];
                mdl_id[0] = mdl_id[mdl_size];
                mdl_arr[0] = mdl_arr[mdl_size];
                i = 0;
                forever begin
                    l = 2 * i + 1;
                    r = l + 1;
                    m = i;
                    if (l < mdl_size && ranks_below(l, m)) m = l;
                    if (r < mdl_size && ranks_below(r, m)) m = r;
                    if (m == i) break;
                    swap_entries(i, m);
                    i = m;
                end
            end
        end
    endfunction

    // mostly short gaps, a few long
    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(40, 150);
    endfunction

    // offer one edge and wait for it to be taken
    task automatic send_edge(logic [ID_W-1:0] id, logic [PROB_W-1:0] prob,
                             logic [PEN_W-1:0] pen, logic first);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid = 1'b1;
        i_edge_id = id;
        i_keep_prob = prob;
        i_penalty_points = pen;
        i_first = first;
        do @(posedge i_clk); while (!o_ready);
        rank_insert(id, prob, pen, first);
    endtask

    task automatic drop_valid();
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    // wait for every expected eviction, then let the block settle
    task automatic wait_idle();
        drop_valid();
        while (pending_evictions.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_KEEP_COUNT:     mdl_keep = data[KEEP_W-1:0];
            CFG_PENALTY_ENABLE: mdl_pen_on = data[0];
            CFG_PENALTY_WEIGHT: mdl_weight = data[WGT_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_regs(int keep, logic pen_on, logic [WGT_W-1:0] wgt);
        wait_idle();
        write_reg(CFG_KEEP_COUNT, {5'($urandom), keep[KEEP_W-1:0]});
        write_reg(CFG_PENALTY_ENABLE, {15'($urandom), pen_on});
        write_reg(CFG_PENALTY_WEIGHT, wgt);
    endtask

    // reset values: keep 1024, raw probability, field extremes
    task automatic test_reset_defaults();
        send_edge(20'h00000, 17'd0, 16'h0000, 1'b1);
        send_edge(20'hFFFFF, 17'd65536, 16'hFFFF, 1'b0);
        send_edge(20'h5A5A5, 17'h1FFFF, 16'h8001, 1'b0);
        send_edge(20'hA5A5A, 17'd1, 16'h7FFE, 1'b0);
    endtask

    // keep count zero evicts every edge at once
    task automatic test_keep_zero();
        set_regs(0, 1'b0, 16'h0000);
        send_edge(20'h00001, 17'd100, 16'h0000, 1'b0);
        send_edge(20'h00002, 17'h1FFFF, 16'hFFFF, 1'b1);
        send_edge(20'h00003, 17'd0, 16'h1234, 1'b0);
    endtask

    // equal priorities: earlier arrival goes out first
    task automatic test_ties();
        set_regs(3, 1'b0, 16'h0000);
        for (int k = 0; k < 6; k++) begin
            send_edge(20'(k + 16), 17'd4096, 16'($urandom), k == 0);
        end
    endtask

    // weighted penalty, largest and smallest weights
    task automatic test_penalty();
        set_regs(2, 1'b1, 16'hFFFF);
        send_edge(20'h11111, 17'd0, 16'hFFFF, 1'b1);
        send_edge(20'h22222, 17'd65536, 16'hFFFF, 1'b0);
        send_edge(20'h33333, 17'h1FFFF, 16'h0001, 1'b0);
        set_regs(2, 1'b1, 16'h0001);
        send_edge(20'h44444, 17'd50, 16'hFFFF, 1'b0);
        send_edge(20'h55555, 17'd50, 16'h0000, 1'b0);
    endtask

    // keep count lowered below the heap size: each edge evicts one, so the heap keeps its size
    task automatic test_shrink();
        set_regs(8, 1'b0, 16'h0000);
        for (int k = 0; k < 8; k++) send_edge(20'($urandom), 17'($urandom), 16'h0, k == 0);
        set_regs(2, 1'b0, 16'h0000);
        for (int k = 0; k < 7; k++) send_edge(20'($urandom), 17'($urandom), 16'h0, 1'b0);
    endtask

    // keep count above the heap depth: a deep heap with no idling, then a lower keep count evicts one per edge
    task automatic test_full_heap();
        set_regs(2047, 1'b1, 16'($urandom));
        quiet = 1'b1;
        for (int k = 0; k < 280; k++) begin
            send_edge(20'($urandom), 17'($urandom_range(0, 65536)), 16'($urandom), k == 0);
        end
        set_regs(200, 1'b1, 16'($urandom));
        for (int k = 0; k < 20; k++) begin
            send_edge(20'($urandom), 17'($urandom_range(0, 65536)), 16'($urandom), 1'b0);
        end
        quiet = 1'b0;
    endtask

    // random phases, small heaps mostly so evictions are frequent
    task automatic test_random();
        int keep;
        int n;
        logic [PROB_W-1:0] prob;
        for (int ph = 0; ph < 10; ph++) begin
            case ($urandom_range(0, 3))
                0: keep = $urandom_range(0, 3);
                1, 2: keep = $urandom_range(1, 16);
                default: keep = $urandom_range(17, 64);
            endcase
            set_regs(keep, 1'($urandom), (ph == 3) ? 16'hFFFF : 16'($urandom));
            quiet = (ph == 5);
            n = $urandom_range(18, 26);
            for (int k = 0; k < n; k++) begin
                // a small set of probabilities makes ties common
                if ($urandom_range(0, 2) == 0) prob = 17'($urandom_range(0, 3) * 8192);
                else prob = 17'($urandom);
                send_edge(20'($urandom), prob, 16'($urandom),
                          (k == 0) || ($urandom_range(0, 39) == 0));
            end
            quiet = 1'b0;
        end
    endtask

    // eviction receiver with random stalls
    always @(negedge i_clk) begin
        if (!quiet && out_stall > 0) begin
            out_stall <= out_stall - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
            out_stall <= quiet ? 0 : pick_gap();
        end
    end

    // compare each eviction with the oldest expectation
    always @(posedge i_clk) begin
        t_eviction ev;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_evictions.size() == 0) begin
                $display("%0t unexpected eviction id %h priority %0d", $time,
                         o_evicted_id, o_evicted_priority);
                errors++;
            end else begin
                ev = pending_evictions.pop_front();
                if (o_evicted_id !== ev.id) begin
                    $display("%0t evicted_id expected %h actual %h", $time,
                             ev.id, o_evicted_id);
                    errors++;
                end
                if (o_evicted_priority !== ev.pri) begin
                    $display("%0t evicted_priority expected %0d actual %0d", $time,
                             ev.pri, o_evicted_priority);
                    errors++;
                end
            end
        end
    end

    // watchdog over cycles with no handshake on any channel
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (i_rst_n) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t watchdog timeout", $time);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        mdl_size = 0;
        mdl_arrivals = '0;
        mdl_keep = 11'd1024;
        mdl_pen_on = 1'b0;
        mdl_weight = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_reset_defaults();
        test_keep_zero();
        test_ties();
        test_penalty();
        test_shrink();
        test_random();
        test_full_heap();
        wait_idle();
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/tkes_pkg.sv
rtl/tkes_ram.sv
rtl/tkes_pri.sv
rtl/top_k_edge_keep_selector.sv
tb/sv/tb_top.sv
